// ===== hdl/m3i_pkg.sv =====
// Package for the 3x3 matrix inverse core: field types, internal widths,
// and the record passed from the cofactor front end to the divider lanes.
// No dependencies.
package m3i_pkg;

    localparam int EL_W    = 16;                 // input element, Q3.12
    localparam int PROD_W  = 2 * EL_W;           // element product
    localparam int ADJ_W   = PROD_W + 1;         // cofactor
    localparam int DP_W    = EL_W + ADJ_W;       // element * cofactor
    localparam int DET_W   = DP_W + 2;           // sum of three terms
    localparam int MC_W    = PROD_W;             // cofactor magnitude
    localparam int MD_W    = DET_W;              // determinant magnitude
    localparam int RES_W   = 32;                 // result element, Q15.16
    localparam int THR_W   = 48;
    localparam int SHIFT   = 28;                 // input fraction 12 + output fraction 16
    localparam int QBITS   = RES_W;              // quotient bits developed per lane
    localparam int PRE_W   = QBITS - SHIFT;      // low cofactor bits fed into the divider
    localparam int LANES   = 9;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(68719);

    typedef struct packed {
        logic signed [EL_W-1:0] a00;
        logic signed [EL_W-1:0] a01;
        logic signed [EL_W-1:0] a02;
        logic signed [EL_W-1:0] a10;
        logic signed [EL_W-1:0] a11;
        logic signed [EL_W-1:0] a12;
        logic signed [EL_W-1:0] a20;
        logic signed [EL_W-1:0] a21;
        logic signed [EL_W-1:0] a22;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_W-1:0] r00;
        logic signed [RES_W-1:0] r01;
        logic signed [RES_W-1:0] r02;
        logic signed [RES_W-1:0] r10;
        logic signed [RES_W-1:0] r11;
        logic signed [RES_W-1:0] r12;
        logic signed [RES_W-1:0] r20;
        logic signed [RES_W-1:0] r21;
        logic signed [RES_W-1:0] r22;
        logic                    singular;
        logic                    saturated;
    } t_out_item;

    // one cofactor ready for division
    typedef struct packed {
        logic [MC_W-1:0] mc;
        logic [MD_W-1:0] md;
        logic            neg;
        logic            singular;
    } t_lane_in;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic             sat;
        logic             singular;
    } t_lane_out;

endpackage

// ===== hdl/m3i_front.sv =====
// Cofactor front end: products, adjugate, determinant and singular test.
// Five register stages. Depends on m3i_pkg.
module m3i_front import m3i_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_in_item         i_item,
    input  logic [THR_W-1:0] i_thr,
    output logic             o_valid,
    output t_lane_in         o_lane [LANES]
);

    logic signed [EL_W-1:0]   a [9];
    logic signed [PROD_W-1:0] r_p [18];
    logic signed [EL_W-1:0]   r_a1 [3];
    logic signed [EL_W-1:0]   r_a2 [3];
    logic signed [ADJ_W-1:0]  r_adj2 [LANES];
    logic signed [ADJ_W-1:0]  r_adj3 [LANES];
    logic signed [ADJ_W-1:0]  r_adj4 [LANES];
    logic signed [DP_W-1:0]   r_dp [3];
    logic signed [DET_W-1:0]  r_det;
    logic [4:0]               r_v;
    t_lane_in                 r_lane [LANES];
    logic [MD_W-1:0]          md;
    logic                     dneg;
    logic                     sing;

    assign a[0] = i_item.a00;
    assign a[1] = i_item.a01;
    assign a[2] = i_item.a02;
    assign a[3] = i_item.a10;
    assign a[4] = i_item.a11;
    assign a[5] = i_item.a12;
    assign a[6] = i_item.a20;
    assign a[7] = i_item.a21;
    assign a[8] = i_item.a22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // stage 1: the eighteen element products, in cofactor pairs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= a[4] * a[8];  r_p[1]  <= a[5] * a[7];
            r_p[2]  <= a[2] * a[7];  r_p[3]  <= a[1] * a[8];
            r_p[4]  <= a[1] * a[5];  r_p[5]  <= a[2] * a[4];
            r_p[6]  <= a[5] * a[6];  r_p[7]  <= a[3] * a[8];
            r_p[8]  <= a[0] * a[8];  r_p[9]  <= a[2] * a[6];
            r_p[10] <= a[2] * a[3];  r_p[11] <= a[0] * a[5];
            r_p[12] <= a[3] * a[7];  r_p[13] <= a[4] * a[6];
            r_p[14] <= a[1] * a[6];  r_p[15] <= a[0] * a[7];
            r_p[16] <= a[0] * a[4];  r_p[17] <= a[1] * a[3];
            r_a1 <= '{a[0], a[1], a[2]};
            r_a2 <= r_a1;
        end
    end

    // stages 2 to 4: cofactors, row-0 terms, determinant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_adj2[k] <= ADJ_W'(r_p[2*k]) - ADJ_W'(r_p[2*k+1]);
            end
            r_dp[0] <= r_a2[0] * r_adj2[0];
            r_dp[1] <= r_a2[1] * r_adj2[3];
            r_dp[2] <= r_a2[2] * r_adj2[6];
            r_adj3  <= r_adj2;
            r_det   <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
            r_adj4  <= r_adj3;
        end
    end

    assign dneg = r_det[DET_W-1];
    assign md   = dneg ? MD_W'(-r_det) : MD_W'(r_det);
    assign sing = md <= MD_W'(i_thr);

    // stage 5: magnitudes and signs per lane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_lane[k].mc <= r_adj4[k][ADJ_W-1] ? MC_W'(-r_adj4[k]) : MC_W'(r_adj4[k]);
                r_lane[k].md <= md;
                r_lane[k].neg <= (r_adj4[k][ADJ_W-1] != dneg) && (r_adj4[k] != '0);
                r_lane[k].singular <= sing;
            end
        end
    end

    assign o_valid = r_v[4];
    assign o_lane  = r_lane;

endmodule

// ===== hdl/m3i_div_lane.sv =====
// One divider lane: |cofactor| * 2^28 / |det|, one quotient bit per stage,
// then clamp and sign. QBITS + 2 register stages. Depends on m3i_pkg.
module m3i_div_lane import m3i_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_lane_in  i_lane,
    output t_lane_out o_lane
);

    logic [MD_W-1:0]  r_rem  [QBITS+1];
    logic [MD_W-1:0]  r_md   [QBITS+1];
    logic [QBITS-1:0] r_feed [QBITS+1];
    logic [QBITS-1:0] r_q    [QBITS+1];
    logic             r_neg  [QBITS+1];
    logic             r_over [QBITS+1];
    logic             r_sing [QBITS+1];
    t_lane_out        r_out;

    logic [RES_W-1:0] lim;
    logic             sat;
    logic [RES_W-1:0] mag;

    // quotient reaches 2^32 exactly when mc >= 16 * md
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_over[0] <= (MD_W+PRE_W)'(i_lane.mc) >= {i_lane.md, PRE_W'(0)};
            r_rem[0]  <= MD_W'(i_lane.mc >> PRE_W);
            r_feed[0] <= {i_lane.mc[PRE_W-1:0], SHIFT'(0)};
            r_q[0]    <= '0;
            r_md[0]   <= i_lane.md;
            r_neg[0]  <= i_lane.neg;
            r_sing[0] <= i_lane.singular;
        end
    end

    for (genvar s = 1; s <= QBITS; s++) begin : g_step
        logic [MD_W:0] sh;
        logic          ge;
        assign sh = {r_rem[s-1], r_feed[s-1][QBITS-1]};
        assign ge = sh >= {1'b0, r_md[s-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? MD_W'(sh - {1'b0, r_md[s-1]}) : MD_W'(sh);
                r_feed[s] <= r_feed[s-1] << 1;
                r_q[s]    <= {r_q[s-1][QBITS-2:0], ge};
                r_md[s]   <= r_md[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_over[s] <= r_over[s-1];
                r_sing[s] <= r_sing[s-1];
            end
        end
    end

    assign lim = r_neg[QBITS] ? {1'b1, (RES_W-1)'(0)} : {1'b0, {(RES_W-1){1'b1}}};
    assign sat = r_over[QBITS] || (r_q[QBITS] > lim);
    assign mag = sat ? lim : r_q[QBITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.res      <= r_neg[QBITS] ? -mag : mag;
            r_out.sat      <= sat;
            r_out.singular <= r_sing[QBITS];
        end
    end

    assign o_lane = r_out;

endmodule

// ===== hdl/m3i_merge.sv =====
// Merge stage: gathers the nine lane results, zeroes singular matrices and
// folds the lane saturation flags. Output register. Depends on m3i_pkg.
module m3i_merge import m3i_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_lane_out i_lane [LANES],
    output t_out_item o_item
);

    logic [RES_W-1:0] res [LANES];
    logic             any_sat;
    logic             sing;
    t_out_item        r_item;

    assign sing = i_lane[0].singular;

    always_comb begin
        any_sat = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            res[k]  = sing ? '0 : i_lane[k].res;
            any_sat = any_sat | i_lane[k].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.r00       <= res[0];
            r_item.r01       <= res[1];
            r_item.r02       <= res[2];
            r_item.r10       <= res[3];
            r_item.r11       <= res[4];
            r_item.r12       <= res[5];
            r_item.r20       <= res[6];
            r_item.r21       <= res[7];
            r_item.r22       <= res[8];
            r_item.singular  <= sing;
            r_item.saturated <= any_sat && !sing;
        end
    end

    assign o_item = r_item;

endmodule

// ===== hdl/matrix3_inverse_core.sv =====
// 3x3 matrix inverse by adjugate. 40 register stages (5 front, 34 divider lane,
// 1 merge holding the output); one matrix per cycle sustained while the output
// is not stalled. The whole pipeline holds while a result waits and the output
// is stalled. Synchronous active-low reset clears valids and sets the threshold
// register to 68719. Depends on m3i_pkg.
module matrix3_inverse_core import m3i_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data
);

    localparam int LANE_LAT = QBITS + 2;

    logic [THR_W-1:0]    r_thr;
    logic                adv;
    logic                front_v;
    t_lane_in            lane_in  [LANES];
    t_lane_out           lane_out [LANES];
    logic [LANE_LAT-1:0] r_lv;
    logic                r_out_valid;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_thr   (r_thr),
        .o_valid (front_v),
        .o_lane  (lane_in)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_lane (lane_in[k]),
            .o_lane (lane_out[k])
        );
    end

    // valid track alongside the lanes, then merge and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv        <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_lv        <= {r_lv[LANE_LAT-2:0], front_v};
            r_out_valid <= r_lv[LANE_LAT-1];
        end
    end

    m3i_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_lane (lane_out),
        .o_item (o_out_data)
    );

    assign o_out_valid = r_out_valid;

endmodule

// ===== dv/matrix3_inverse_core_tb.sv =====
// Testbench for matrix3_inverse_core: drives random and corner matrices, predicts
// the adjugate inverse per transfer and checks every output field in order.
// Depends on m3i_pkg and the core RTL.
`timescale 1ns / 100ps

module matrix3_inverse_core_tb;
    import m3i_pkg::*;

    localparam int LATENCY = 41;
    localparam int N_RANDOM = 1700;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_data;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_data;

    t_in_item  pending_mats[$];
    t_out_item inverse_due[$];
    logic [THR_W-1:0] thr_model;
    int  n_errors;
    int  in_gap;
    int  out_gap;
    int  hold_cycles;
    bit  stim_done;

    matrix3_inverse_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // c * 2^28 / d, truncated toward zero, clamped to 32 bits
    function automatic logic [RES_W-1:0] scaled_quot(longint c, longint d, ref bit sat);
        logic [127:0] mc;
        logic [127:0] md;
        logic [127:0] q;
        logic [127:0] lim;
        bit neg;
        mc = (c < 0) ? 128'(-c) : 128'(c);
        md = (d < 0) ? 128'(-d) : 128'(d);
        neg = ((c < 0) != (d < 0)) && (mc != 0);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        q = (mc << SHIFT) / md;
        if (q > lim) begin
            sat = 1'b1;
            q = lim;
        end
        return neg ? RES_W'(-q) : RES_W'(q);
    endfunction

    function automatic t_out_item inverse_of(t_in_item m, logic [THR_W-1:0] thr);
        longint a[9];
        longint adj[9];
        longint det;
        longint dmag;
        logic [RES_W-1:0] r[9];
        bit sat;
        t_out_item o;
        a = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[2]*a[3] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[1]*a[6] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        dmag = (det < 0) ? -det : det;
        o = '0;
        if (dmag <= longint'(thr)) begin
            o.singular = 1'b1;
            return o;
        end
        sat = 1'b0;
        for (int i = 0; i < 9; i++)
            r[i] = scaled_quot(adj[i], det, sat);
        o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
        o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
        o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
        o.saturated = sat;
        return o;
    endfunction

    function automatic logic signed [EL_W-1:0] rand_elem(int style);
        case (style)
            0: return EL_W'($urandom);
            1: return EL_W'($urandom_range(0, 8192)) - 16'sd4096;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return EL_W'($urandom_range(0, 16)) - 16'sd8;
        endcase
    endfunction

    function automatic t_in_item rand_matrix();
        t_in_item m;
        int style;
        style = $urandom_range(0, 9);
        if (style < 4) begin
            // near-identity with noise, well conditioned
            m.a00 = 16'sd4096 + rand_elem(3) * 100; m.a01 = rand_elem(1) >>> 3;
            m.a02 = rand_elem(1) >>> 3; m.a10 = rand_elem(1) >>> 3;
            m.a11 = 16'sd4096 + rand_elem(3) * 100; m.a12 = rand_elem(1) >>> 3;
            m.a20 = rand_elem(1) >>> 3; m.a21 = rand_elem(1) >>> 3;
            m.a22 = 16'sd4096 + rand_elem(3) * 100;
            if ($urandom_range(0, 1)) m.a00 = -m.a00;
        end else begin
            style = (style == 9) ? 2 : (style == 8) ? 3 : (style > 5) ? 0 : 1;
            m = {rand_elem(style), rand_elem(style), rand_elem(style),
                 rand_elem(style), rand_elem(style), rand_elem(style),
                 rand_elem(style), rand_elem(style), rand_elem(style)};
            // rank-deficient: copy one row into another
            if ($urandom_range(0, 7) == 0) begin
                m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
            end
        end
        return m;
    endfunction

    task automatic add_diag(logic signed [EL_W-1:0] x, logic signed [EL_W-1:0] y,
                            logic signed [EL_W-1:0] z);
        t_in_item m;
        m = '0;
        m.a00 = x; m.a11 = y; m.a22 = z;
        pending_mats.push_back(m);
    endtask

    task automatic wait_drained();
        while (pending_mats.size() != 0 || in_valid || inverse_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        thr_model = v;
    endtask

    // driver: random idle gap drawn after each transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                inverse_due.push_back(inverse_of(in_data, thr_model));
                in_gap = $urandom_range(0, 4);
                if (hold_cycles == 0 && $urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (!(in_valid && in_stall)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_mats.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_mats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk) begin
        t_out_item exp_o;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (inverse_due.size() == 0) begin
                    $error("unexpected result transfer");
                    n_errors++;
                end else begin
                    exp_o = inverse_due.pop_front();
                    if (out_data.r00 !== exp_o.r00) begin $error("r00 exp %0d got %0d", exp_o.r00, out_data.r00); n_errors++; end
                    if (out_data.r01 !== exp_o.r01) begin $error("r01 exp %0d got %0d", exp_o.r01, out_data.r01); n_errors++; end
                    if (out_data.r02 !== exp_o.r02) begin $error("r02 exp %0d got %0d", exp_o.r02, out_data.r02); n_errors++; end
                    if (out_data.r10 !== exp_o.r10) begin $error("r10 exp %0d got %0d", exp_o.r10, out_data.r10); n_errors++; end
                    if (out_data.r11 !== exp_o.r11) begin $error("r11 exp %0d got %0d", exp_o.r11, out_data.r11); n_errors++; end
                    if (out_data.r12 !== exp_o.r12) begin $error("r12 exp %0d got %0d", exp_o.r12, out_data.r12); n_errors++; end
                    if (out_data.r20 !== exp_o.r20) begin $error("r20 exp %0d got %0d", exp_o.r20, out_data.r20); n_errors++; end
                    if (out_data.r21 !== exp_o.r21) begin $error("r21 exp %0d got %0d", exp_o.r21, out_data.r21); n_errors++; end
                    if (out_data.r22 !== exp_o.r22) begin $error("r22 exp %0d got %0d", exp_o.r22, out_data.r22); n_errors++; end
                    if (out_data.singular !== exp_o.singular) begin
                        $error("singular exp %0b got %0b", exp_o.singular, out_data.singular); n_errors++;
                    end
                    if (out_data.saturated !== exp_o.saturated) begin
                        $error("saturated exp %0b got %0b", exp_o.saturated, out_data.saturated); n_errors++;
                    end
                end
                out_gap = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) out_gap = 0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        cfg_we = 1'b0; cfg_data = '0;
        thr_model = THR_RESET;
        n_errors = 0; in_gap = 0; out_gap = 0; hold_cycles = 0; stim_done = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, scaled, negatives, extremes, zero, singular, overflow
        add_diag(16'sd4096, 16'sd4096, 16'sd4096);
        add_diag(16'sd8192, -16'sd4096, 16'sd2048);
        add_diag(16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_diag(16'sh8000, 16'sh8000, 16'sh8000);
        add_diag(16'sh8000, 16'sh7fff, -16'sd1);
        add_diag(16'sd1, 16'sd1, 16'sd1);
        add_diag(16'sd64, 16'sd64, 16'sd64);
        add_diag(16'sd0, 16'sd0, 16'sd0);
        pending_mats.push_back({9{16'sh7fff}});
        pending_mats.push_back({9{16'sh8000}});
        pending_mats.push_back({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000});
        pending_mats.push_back({16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd4096,
                                16'sd4096, 16'sd0, 16'sd0});
        pending_mats.push_back({16'sd4096, 16'sd8192, 16'sd12288, 16'sd4096, 16'sd8192,
                                16'sd12288, 16'sd1, 16'sd2, 16'sd3});
        pending_mats.push_back({16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 16'sh0f0f,
                                16'shf0f0, 16'sh3333, 16'shcccc, 16'sh7ffe});
        write_threshold('0);
        add_diag(16'sd1, 16'sd1, 16'sd1);
        add_diag(16'sd0, 16'sd4096, 16'sd4096);
        add_diag(16'sd1, 16'sd1, -16'sd2);
        write_threshold({THR_W{1'b1}});
        add_diag(16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_diag(16'sh8000, 16'sh8000, 16'sh8000);
        write_threshold(THR_W'(68719));
        add_diag(16'sd41, 16'sd41, 16'sd41);  // just above the default threshold
        add_diag(16'sd40, 16'sd41, 16'sd41);  // just below it

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) begin
                wait_drained();
                hold_cycles = 150;  // long receiver hold while the driver keeps feeding
                for (int k = 0; k < 120; k++) pending_mats.push_back(rand_matrix());
            end
            if (i == 700) write_threshold(THR_W'($urandom_range(0, 32'hffff_ffff)));
            if (i == 1100) write_threshold(THR_W'({$urandom, $urandom}));
            if (i == 1400) write_threshold(THR_W'(68719));
            pending_mats.push_back(rand_matrix());
            if (pending_mats.size() > 8) @(posedge clk);
        end
        wait_drained();
        stim_done = 1'b1;
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
